[sv/deq_pkg.sv]
`timescale 1ns / 1ps

package deq_pkg;

    // ring geometry
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 5;

    // command codes
    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } cmd_t;

    // status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_ACCESS = 2'd1,
        S_FORM   = 2'd2
    } state_t;

    // request payload
    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] value;
    } req_t;

    // result payload
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] removed_value;
        logic [ENTRY_W-1:0]       entry_count;
    } res_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic access;
        logic form;
    } ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic res_valid;
    } stat_t;

endpackage

[sv/deq_ctrl.sv]
`timescale 1ns / 1ps

module deq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            res_stall,
    input  deq_pkg::stat_t  stat,
    output deq_pkg::ctrl_t  ctrl,
    output logic            req_stall
);

    deq_pkg::state_t state_reg;
    deq_pkg::state_t state_next;
    logic            form_ok;

    // output register free or being emptied this cycle
    assign form_ok = !stat.res_valid || !res_stall;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = deq_pkg::S_ACCESS;
                end
            end
            deq_pkg::S_ACCESS:
            begin
                state_next = deq_pkg::S_FORM;
            end
            deq_pkg::S_FORM:
            begin
                if (form_ok)
                begin
                    state_next = deq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl      = '0;
        req_stall = 1'b1;
        case (state_reg)
            deq_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                ctrl.load = req_valid;
            end
            deq_pkg::S_ACCESS:
            begin
                ctrl.access = 1'b1;
            end
            deq_pkg::S_FORM:
            begin
                ctrl.form = form_ok;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

[sv/deq_datapath.sv]
`timescale 1ns / 1ps

module deq_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  deq_pkg::ctrl_t  ctrl,
    input  deq_pkg::req_t   req,
    input  logic            res_stall,
    output deq_pkg::stat_t  stat,
    output deq_pkg::res_t   res,
    output logic            res_valid
);

    localparam logic [deq_pkg::IDX_W-1:0] LAST_IDX = deq_pkg::IDX_W'(deq_pkg::DEPTH - 1);
    localparam logic [deq_pkg::CNT_W-1:0] FULL_CNT = deq_pkg::CNT_W'(deq_pkg::DEPTH);
    localparam logic [deq_pkg::CNT_W:0]   WRAP_SUM = (deq_pkg::CNT_W + 1)'(deq_pkg::DEPTH);

    // entry ring
    logic [deq_pkg::DATA_W-1:0] mem [deq_pkg::DEPTH];

    // latched request
    deq_pkg::cmd_t              cmd_reg;
    logic [deq_pkg::DATA_W-1:0] value_reg;

    // queue pointers
    logic [deq_pkg::IDX_W-1:0]  front_reg;
    logic [deq_pkg::IDX_W-1:0]  front_next;
    logic [deq_pkg::CNT_W-1:0]  count_reg;
    logic [deq_pkg::CNT_W-1:0]  count_next;

    // access outcome
    deq_pkg::status_t           status_reg;
    deq_pkg::status_t           status_next;
    logic                       take_reg;
    logic                       take_next;
    logic [deq_pkg::DATA_W-1:0] rd_data_reg;

    // output register
    deq_pkg::res_t              res_reg;
    deq_pkg::res_t              res_next;
    logic                       res_valid_reg;

    logic                       full;
    logic                       empty;
    logic [deq_pkg::IDX_W-1:0]  front_m1;
    logic [deq_pkg::IDX_W-1:0]  front_p1;
    logic [deq_pkg::CNT_W:0]    back_sum;
    logic [deq_pkg::IDX_W-1:0]  back_pos;
    logic [deq_pkg::IDX_W-1:0]  last_pos;
    logic [deq_pkg::IDX_W-1:0]  addr;
    logic                       wr_en;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    // neighbor positions around the front, wrapping at the ring end
    assign front_m1 = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign front_p1 = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;

    // slot after the back entry: front plus count, one conditional subtract
    assign back_sum = (deq_pkg::CNT_W + 1)'(front_reg) + (deq_pkg::CNT_W + 1)'(count_reg);
    assign back_pos = (back_sum >= WRAP_SUM) ? deq_pkg::IDX_W'(back_sum - WRAP_SUM)
                                             : deq_pkg::IDX_W'(back_sum);
    assign last_pos = (back_pos == '0) ? LAST_IDX : back_pos - 1'b1;

    // command decode and pointer update
    always_comb
    begin
        addr        = front_reg;
        wr_en       = 1'b0;
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = deq_pkg::ST_DONE;
        take_next   = 1'b0;
        case (cmd_reg)
            deq_pkg::CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    addr       = front_m1;
                    wr_en      = 1'b1;
                    front_next = front_m1;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    addr       = back_pos;
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    addr       = front_reg;
                    take_next  = 1'b1;
                    front_next = front_p1;
                    count_next = count_reg - 1'b1;
                end
            end
            deq_pkg::CMD_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    addr       = last_pos;
                    take_next  = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = deq_pkg::ST_DONE;
            end
        endcase
    end

    // ring write and registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.access)
        begin
            if (wr_en)
            begin
                mem[addr] <= value_reg;
            end
            rd_data_reg <= mem[addr];
        end
    end

    // result assembly
    always_comb
    begin
        res_next.status        = status_reg;
        res_next.removed_value = take_reg ? rd_data_reg : '0;
        res_next.entry_count   = deq_pkg::ENTRY_W'(count_reg);
    end

    // request latch, access outcome and result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= deq_pkg::cmd_t'(req.cmd);
            value_reg <= req.value;
        end
        if (ctrl.access)
        begin
            status_reg <= status_next;
            take_reg   <= take_next;
        end
        if (ctrl.form)
        begin
            res_reg <= res_next;
        end
    end

    // pointers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.access)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            if (ctrl.form)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.res_valid = res_valid_reg;
    assign res            = res_reg;
    assign res_valid      = res_valid_reg;

endmodule

[sv/double_ended_queue.sv]
`timescale 1ns / 1ps

// channel   handshake              payload
// -------   --------------------   ----------------------------------------
// request   req_valid, req_stall   req: cmd, value
// result    res_valid, res_stall   res: status, removed_value, entry_count
//
// each request passes through latch, ring access and result load in turn
// the single-port ring and its registered read keep these steps apart
// a new request is taken again once the result is in the output register
// rst_n clears front pointer, count and output valid; ring contents stay
// a stalled result holds the output register; the next request may be
// latched and accessed meanwhile and waits in result load

module double_ended_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  deq_pkg::req_t  req,
    output logic           res_valid,
    input  logic           res_stall,
    output deq_pkg::res_t  res
);

    deq_pkg::ctrl_t ctrl;
    deq_pkg::stat_t stat;

    // sequencer
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .ctrl      (ctrl),
        .req_stall (req_stall)
    );

    // ring, pointers and output register
    deq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .req       (req),
        .res_stall (res_stall),
        .stat      (stat),
        .res       (res),
        .res_valid (res_valid)
    );

endmodule
